// File: design/morse_key_letter_decoder_macros.svh
// ----------------------------------------------------------------------------
// Morse letter decoder assertion macros
// Shared concurrent assertion wrappers, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_LETTER_DECODER_MACROS_SVH
`define MORSE_KEY_LETTER_DECODER_MACROS_SVH

// property that must hold at every edge
`define MKLD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MKLD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MKLD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mkld_pkg.sv
// ----------------------------------------------------------------------------
// mkld_pkg
// Types, register map, symbol and letter codes of the Morse letter decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mkld_pkg;

    localparam int TICK_W    = 16;
    localparam int PAT_MAX_W = 16;   // two bits per symbol, up to eight symbols
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [1:0]           sym_t;
    typedef logic [PAT_MAX_W-1:0] pat_t;
    typedef logic [2:0]           letter_t;

    localparam tick_t TICK_MAX = 16'hFFFF;

    // register reset values
    localparam tick_t DASH_THR_RST  = 16'd400;
    localparam tick_t GAP_END_RST   = 16'd1500;
    localparam tick_t GAP_TOUT_RST  = 16'd3000;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DASH_THR = 2'd0;
    localparam logic [1:0] REG_GAP_END  = 2'd1;
    localparam logic [1:0] REG_GAP_TOUT = 2'd2;

    // symbol codes
    localparam sym_t SYM_NONE = 2'd0;
    localparam sym_t SYM_DOT  = 2'd1;
    localparam sym_t SYM_DASH = 2'd2;

    // letter codes
    localparam letter_t LTR_INVALID = 3'd0;
    localparam letter_t LTR_A       = 3'd1;
    localparam letter_t LTR_B       = 3'd2;
    localparam letter_t LTR_C       = 3'd3;
    localparam letter_t LTR_D       = 3'd4;
    localparam letter_t LTR_E       = 3'd5;
    localparam letter_t LTR_R       = 3'd6;
    localparam letter_t LTR_U       = 3'd7;

    // letter patterns, first symbol in the low bits
    localparam pat_t PAT_A = 16'd9;    // .-
    localparam pat_t PAT_B = 16'd86;   // -...
    localparam pat_t PAT_C = 16'd102;  // -.-.
    localparam pat_t PAT_D = 16'd22;   // -..
    localparam pat_t PAT_E = 16'd1;    // .
    localparam pat_t PAT_R = 16'd25;   // .-.
    localparam pat_t PAT_U = 16'd37;   // ..-

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_PRESS = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    typedef struct packed {
        tick_t dash_threshold;
        tick_t gap_end_limit;
        tick_t gap_timeout;
    } cfg_t;

    typedef struct packed {
        letter_t     letter_code;
        logic [2:0]  symbol_count;
        logic [9:0]  symbol_pattern;
    } result_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } outq_status_t;

    function automatic letter_t letter_lookup(input pat_t pat);
        letter_t code;
        begin
            case (pat)
                PAT_A:   code = LTR_A;
                PAT_B:   code = LTR_B;
                PAT_C:   code = LTR_C;
                PAT_D:   code = LTR_D;
                PAT_E:   code = LTR_E;
                PAT_R:   code = LTR_R;
                PAT_U:   code = LTR_U;
                default: code = LTR_INVALID;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/mkld_core.sv
// ----------------------------------------------------------------------------
// mkld_core
// Tick register, press/gap timing, symbol store and letter lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module mkld_core #(
    parameter int MAX_SYMBOLS = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_accept,
    input  wire logic              key_down,
    input  wire mkld_pkg::cfg_t    cfg,
    output logic                   pipe_valid,
    output logic                   push,
    output mkld_pkg::result_t      push_data
);
    import mkld_pkg::*;

`include "morse_key_letter_decoder_macros.svh"

    localparam int CW = $clog2(MAX_SYMBOLS + 1);

    logic            pipe_valid_reg;
    logic            key_reg;
    phase_t          phase_reg, phase_next;
    tick_t           press_reg, press_next;
    tick_t           gap_reg, gap_next;
    logic [CW-1:0]   taken_reg, taken_next;
    sym_t            sym_reg  [MAX_SYMBOLS];
    sym_t            sym_next [MAX_SYMBOLS];

    logic            emit;
    logic            release_sym;
    sym_t            new_sym;
    tick_t           press_inc;
    tick_t           gap_inc;
    logic [CW-1:0]   cnt_up;
    logic [CW-1:0]   cnt_emit;
    pat_t            pat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            phase_reg      <= PH_WAIT;
            press_reg      <= '0;
            gap_reg        <= '0;
            taken_reg      <= '0;
        end
        else
        begin
            pipe_valid_reg <= in_accept;
            phase_reg      <= phase_next;
            press_reg      <= press_next;
            gap_reg        <= gap_next;
            taken_reg      <= taken_next;
        end
    end

    // payload: tick level and symbols (entries past the count are masked)
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg <= key_down;
        end
        for (int k = 0; k < MAX_SYMBOLS; k++)
        begin
            sym_reg[k] <= sym_next[k];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        press_next  = press_reg;
        gap_next    = gap_reg;
        taken_next  = taken_reg;
        emit        = 1'b0;
        release_sym = 1'b0;

        cnt_up    = taken_reg + CW'(1);
        new_sym   = (press_reg >= cfg.dash_threshold) ? SYM_DASH : SYM_DOT;
        press_inc = (press_reg == TICK_MAX) ? press_reg : press_reg + 16'd1;
        gap_inc   = (gap_reg == TICK_MAX) ? gap_reg : gap_reg + 16'd1;

        if (pipe_valid_reg)
        begin
            case (phase_reg)
                PH_PRESS:
                begin
                    if (key_reg)
                    begin
                        press_next = press_inc;
                    end
                    else
                    begin
                        release_sym = 1'b1;
                        taken_next  = cnt_up;
                        phase_next  = PH_WAIT;
                        if (cnt_up == CW'(MAX_SYMBOLS))
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            gap_next   = 16'd1;
                            phase_next = PH_GAP;
                            emit       = (16'd1 > cfg.gap_timeout);
                        end
                    end
                end
                PH_GAP:
                begin
                    if (key_reg)
                    begin
                        emit       = (gap_reg > cfg.gap_end_limit);
                        press_next = 16'd1;
                        phase_next = PH_PRESS;
                    end
                    else
                    begin
                        gap_next = gap_inc;
                        emit     = (gap_inc > cfg.gap_timeout);
                    end
                end
                default:
                begin
                    // waiting, and the unused phase code
                    if (key_reg)
                    begin
                        press_next = 16'd1;
                        phase_next = PH_PRESS;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
            endcase

            // letter done: clear; a press that ended it keeps running
            if (emit)
            begin
                taken_next = '0;
                gap_next   = '0;
                if (phase_next != PH_PRESS)
                begin
                    phase_next = PH_WAIT;
                    press_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_SYMBOLS; k++)
        begin
            sym_next[k] = sym_reg[k];
            if (release_sym && (taken_reg == CW'(k)))
            begin
                sym_next[k] = new_sym;
            end
        end
    end

    // pattern of the finished letter, including a symbol released this tick
    assign cnt_emit = release_sym ? cnt_up : taken_reg;

    always_comb
    begin
        pat = '0;
        for (int k = 0; k < MAX_SYMBOLS; k++)
        begin
            if (CW'(k) < cnt_emit)
            begin
                pat[2*k +: 2] = sym_next[k];
            end
        end
    end

    assign pipe_valid               = pipe_valid_reg;
    assign push                     = emit;
    assign push_data.letter_code    = letter_lookup(pat);
    assign push_data.symbol_count   = 3'(cnt_emit);
    assign push_data.symbol_pattern = pat[9:0];

    `MKLD_ASSERT_IMPL(a_press_nonzero, phase_reg == PH_PRESS, press_reg != '0,
        "press phase with zero press count")
    `MKLD_ASSERT(a_taken_bound, taken_reg < CW'(MAX_SYMBOLS),
        "symbol count reached the letter limit without a result")
    `MKLD_ASSERT_IMPL(a_wait_empty, phase_reg == PH_WAIT, taken_reg == '0,
        "idle phase holds stale symbols")

endmodule

`default_nettype wire

// File: design/mkld_outq.sv
// ----------------------------------------------------------------------------
// mkld_outq
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module mkld_outq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire mkld_pkg::result_t      push_data,
    input  wire logic                   out_stall,
    output mkld_pkg::result_t           out_data,
    output mkld_pkg::outq_status_t      status
);
    import mkld_pkg::*;

`include "morse_key_letter_decoder_macros.svh"

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    result_t  out_data_reg, out_data_next;
    result_t  skid_data_reg, skid_data_next;
    logic     pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_data          = out_data_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.skid_valid = skid_valid_reg;

    `MKLD_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held with empty result register")
    `MKLD_ASSERT_IMPL(a_no_overflow, push, !skid_valid_reg,
        "result arrived with both entries full")
    `MKLD_ASSERT_NEXT(a_push_lands, push && !out_valid_reg, out_valid_reg,
        "result lost on an empty queue")

endmodule

`default_nettype wire

// File: design/morse_key_letter_decoder.sv
// ----------------------------------------------------------------------------
// morse_key_letter_decoder
// Times Morse key presses per millisecond tick and emits one decoded letter.
// ----------------------------------------------------------------------------
// One tick request per clock: every request carries the key level for one
// millisecond, and a new one is taken in every cycle as long as in_stall is
// low. The tick goes into an input register, the timing and decode logic
// updates the letter state from there, and a finished letter lands in the
// result register. A skid entry behind the result register lets ticks keep
// flowing while a result waits; in_stall rises only once that entry is taken,
// or while the result register is full with a tick still in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_key_letter_decoder #(
    parameter int MAX_SYMBOLS = 5    // symbols per letter, 1 to 5 (symbol_pattern holds five)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // tick requests
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       key_down,
    // letter results
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [2:0]                      letter_code,
    output logic [2:0]                      symbol_count,
    output logic [9:0]                      symbol_pattern,
    // register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mkld_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mkld_pkg::DATA_W-1:0] pwdata,
    output logic [mkld_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import mkld_pkg::*;

    // register file
    tick_t         dash_thr_reg;
    tick_t         gap_end_reg;
    tick_t         gap_tout_reg;
    logic          cfg_wr;
    logic [1:0]    reg_idx;
    cfg_t          cfg;

    logic          in_accept;
    logic          core_busy;
    logic          push;
    result_t       push_data;
    result_t       out_data;
    outq_status_t  q_status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_thr_reg <= DASH_THR_RST;
            gap_end_reg  <= GAP_END_RST;
            gap_tout_reg <= GAP_TOUT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_DASH_THR: dash_thr_reg <= pwdata[TICK_W-1:0];
                REG_GAP_END:  gap_end_reg  <= pwdata[TICK_W-1:0];
                REG_GAP_TOUT: gap_tout_reg <= pwdata[TICK_W-1:0];
                default:      ;   // unmapped: write dropped
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DASH_THR: prdata = {{(DATA_W-TICK_W){1'b0}}, dash_thr_reg};
            REG_GAP_END:  prdata = {{(DATA_W-TICK_W){1'b0}}, gap_end_reg};
            REG_GAP_TOUT: prdata = {{(DATA_W-TICK_W){1'b0}}, gap_tout_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.dash_threshold = dash_thr_reg;
    assign cfg.gap_end_limit  = gap_end_reg;
    assign cfg.gap_timeout    = gap_tout_reg;

    // Each tick yields at most one result. Stall only when the queue could not
    // absorb the tick in flight plus this one: skid full, or result register
    // full while the input register holds a tick.
    assign in_stall  = q_status.skid_valid || (q_status.out_valid && core_busy);
    assign in_accept = in_valid && !in_stall;

    mkld_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .key_down   (key_down),
        .cfg        (cfg),
        .pipe_valid (core_busy),
        .push       (push),
        .push_data  (push_data)
    );

    mkld_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_stall (out_stall),
        .out_data  (out_data),
        .status    (q_status)
    );

    assign out_valid      = q_status.out_valid;
    assign letter_code    = out_data.letter_code;
    assign symbol_count   = out_data.symbol_count;
    assign symbol_pattern = out_data.symbol_pattern;

endmodule

`default_nettype wire
